FILE: sv/bsa_pkg.sv
package bsa_pkg;

  // Default sizing of the allocator.
  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned WORD_WIDTH  = 64;
  localparam int unsigned MAX_REQUEST = 64;

  // Fixed field widths of the ports.
  localparam int unsigned NUM_BITS_W = 11;
  localparam int unsigned REQ_W      = 7;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [NUM_BITS_W-1:0] NUM_BITS_RESET = 11'd1024;

  // Operation codes of an input beat.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [63:0] PC_M0 = 64'h5555555555555555;
  localparam logic [63:0] PC_M1 = 64'h3333333333333333;
  localparam logic [63:0] PC_M2 = 64'h0F0F0F0F0F0F0F0F;
  localparam logic [63:0] PC_M3 = 64'h00FF00FF00FF00FF;
  localparam logic [63:0] PC_M4 = 64'h0000FFFF0000FFFF;
  localparam logic [63:0] PC_M5 = 64'h00000000FFFFFFFF;

  // Population count of a 64-bit word by pairwise folding of bit fields.
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [63:0] x;
    x = ((v >> 1) & PC_M0) + (v & PC_M0);
    x = ((x >> 2) & PC_M1) + (x & PC_M1);
    x = ((x >> 4) & PC_M2) + (x & PC_M2);
    x = ((x >> 8) & PC_M3) + (x & PC_M3);
    x = ((x >> 16) & PC_M4) + (x & PC_M4);
    x = ((x >> 32) & PC_M5) + (x & PC_M5);
    return x[6:0];
  endfunction

endpackage

FILE: sv/bsa_map_ram.sv
// Occupancy word store: one write port, one read port with registered data.
module bsa_map_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bitmap_slot_allocator.sv
// Sequence: a free beat is classified, then steps word by word to the word holding its slot,
// clears that bit and answers; a bad request or an out-of-range free answers right after
// classification. An allocate beat first counts the free slots of every bitmap word and fails
// if too few are free, else it picks slots word by word and writes each word back.
// One beat at a time: input reopens with the last result or after the final pick write-back.
// Reset is asynchronous, active low, then a clearing pass zeroes one word per cycle.
module bitmap_slot_allocator #(
  parameter int unsigned CAPACITY    = bsa_pkg::CAPACITY,
  parameter int unsigned WORD_WIDTH  = bsa_pkg::WORD_WIDTH,
  parameter int unsigned MAX_REQUEST = bsa_pkg::MAX_REQUEST
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel: the slot count in use.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsa_pkg::NUM_BITS_W-1:0] cfg_num_bits_i,
  // Request channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [bsa_pkg::REQ_W-1:0]     request_count_i,
  input  logic [bsa_pkg::IDX_W-1:0]     free_index_i,
  input  logic                          batch_last_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bsa_pkg::STATUS_W-1:0]  status_o,
  output logic [bsa_pkg::IDX_W-1:0]     slot_o,
  output logic                          last_o
);

  // Derived sizes. The bitmap is stored as NWORDS words of WORD_WIDTH bits.
  localparam int unsigned NWORDS  = (CAPACITY + WORD_WIDTH - 1) / WORD_WIDTH;
  localparam int unsigned WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned BIT_W   = $clog2(WORD_WIDTH);
  localparam int unsigned BASE_W  = $clog2(NWORDS * WORD_WIDTH + 1);
  localparam int unsigned CMP_W   = (BASE_W > bsa_pkg::NUM_BITS_W) ? BASE_W
                                                                   : bsa_pkg::NUM_BITS_W;
  localparam int unsigned IDX_W   = bsa_pkg::IDX_W;
  localparam int unsigned REQ_W   = bsa_pkg::REQ_W;

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;  // post-reset clearing pass
  localparam logic [3:0] S_IDLE  = 4'd1;  // waiting for a request beat
  localparam logic [3:0] S_START = 4'd2;  // classify the latched request
  localparam logic [3:0] S_EMIT  = 4'd3;  // send a single result beat
  localparam logic [3:0] S_FDIV  = 4'd4;  // locate the word holding a freed slot
  localparam logic [3:0] S_FWR   = 4'd5;  // clear the slot bit and write back
  localparam logic [3:0] S_CRD   = 4'd6;  // count pass: wait for read data
  localparam logic [3:0] S_CACC  = 4'd7;  // count pass: accumulate free bits
  localparam logic [3:0] S_CDEC  = 4'd8;  // compare free count with request
  localparam logic [3:0] S_PRD   = 4'd9;  // pick pass: wait for read data
  localparam logic [3:0] S_PLOAD = 4'd10; // pick pass: load word and free mask
  localparam logic [3:0] S_PICK  = 4'd11; // hand out one slot per cycle unless the output stalls
  localparam logic [3:0] S_PWB   = 4'd12; // write the updated word back

  // Lowest set bit of a word.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_WIDTH-1:0] v);
    logic [BIT_W-1:0] k;
    k = '0;
    for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = BIT_W'(i);
      end
    end
    return k;
  endfunction

  logic [3:0]                    state_q, state_d;
  logic [bsa_pkg::NUM_BITS_W-1:0] num_bits_q;
  logic [WADDR_W-1:0]            ptr_q, ptr_d;
  logic [BASE_W-1:0]             base_q, base_d;
  logic [BASE_W-1:0]             cnt_q, cnt_d;
  logic [REQ_W-1:0]              n_q, n_d;
  logic [IDX_W-1:0]              rem_q, rem_d;

  // Latched request fields and the pending single-beat status.
  logic                          func_q;
  logic [REQ_W-1:0]              req_q;
  logic [IDX_W-1:0]              idx_q;
  logic                          blast_q;
  logic [bsa_pkg::STATUS_W-1:0]  pend_st_q, pend_st_d;

  // Word being picked from: occupancy and still-available slots.
  logic [WORD_WIDTH-1:0]         cur_q, cur_d;
  logic [WORD_WIDTH-1:0]         avail_q, avail_d;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic [bsa_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [IDX_W-1:0]              slot_q, slot_d;
  logic                          last_q, last_d;

  // Bitmap store port.
  logic                          mem_we;
  logic [WADDR_W-1:0]            mem_waddr;
  logic [WORD_WIDTH-1:0]         mem_wdata;
  logic [WORD_WIDTH-1:0]         mem_rdata;

  logic                          in_fire;
  logic                          out_free;
  logic [CMP_W-1:0]              nb_eff;
  logic [CMP_W-1:0]              base_ext;
  logic [CMP_W-1:0]              span;
  logic [WORD_WIDTH-1:0]         valid_mask;
  logic [WORD_WIDTH-1:0]         taken;
  logic [6:0]                    taken_cnt;
  logic [6:0]                    free_cnt;
  logic [BIT_W-1:0]              pick_bit;
  logic                          last_word;

  bsa_map_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_WIDTH),
    .ADDR_W(WADDR_W)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(ptr_q),
    .rdata_o(mem_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign last_word   = (ptr_q == WADDR_W'(NWORDS - 1));

  // A slot count above the capacity is clamped to the capacity.
  assign nb_eff = (CMP_W'(num_bits_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                          : CMP_W'(num_bits_q);

  // Slots of the current word that lie below the effective slot count. The
  // word starts at slot base_q; bits past the count are treated as taken.
  assign base_ext = CMP_W'(base_q);
  assign span     = nb_eff - base_ext;
  always_comb begin
    if (nb_eff <= base_ext) begin
      valid_mask = '0;
    end else if (span >= CMP_W'(WORD_WIDTH)) begin
      valid_mask = '1;
    end else begin
      valid_mask = ~({WORD_WIDTH{1'b1}} << span[BIT_W-1:0]);
    end
  end

  // The counting unit: free slots in the word just read.
  assign taken     = mem_rdata | ~valid_mask;
  assign taken_cnt = bsa_pkg::popcount64(64'(taken));
  assign free_cnt  = 7'(WORD_WIDTH) - taken_cnt;

  assign pick_bit = lowest_set(avail_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    rem_d       = rem_q;
    pend_st_d   = pend_st_q;
    cur_d       = cur_q;
    avail_d     = avail_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    status_d    = status_q;
    slot_d      = slot_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = cur_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (last_word) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          state_d = S_START;
        end
      end

      S_START: begin
        ptr_d  = '0;
        base_d = '0;
        cnt_d  = '0;
        n_d    = '0;
        rem_d  = idx_q;
        if (func_q == bsa_pkg::FUNC_FREE) begin
          if (CMP_W'(idx_q) >= nb_eff) begin
            pend_st_d = bsa_pkg::ST_RANGE;
            state_d   = S_EMIT;
          end else begin
            state_d = S_FDIV;
          end
        end else if (req_q == '0 || req_q > REQ_W'(MAX_REQUEST)) begin
          pend_st_d = bsa_pkg::ST_NO_FREE;
          state_d   = S_EMIT;
        end else begin
          state_d = S_CRD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = pend_st_q;
          if (pend_st_q == bsa_pkg::ST_NO_FREE) begin
            slot_d = '0;
            last_d = 1'b1;
          end else begin
            slot_d = idx_q;
            last_d = blast_q;
          end
          state_d = S_IDLE;
        end
      end

      // Repeated subtraction turns the slot index into word and bit.
      S_FDIV: begin
        if (rem_q >= IDX_W'(WORD_WIDTH)) begin
          rem_d = rem_q - IDX_W'(WORD_WIDTH);
          ptr_d = ptr_q + 1'b1;
        end else begin
          state_d = S_FWR;
        end
      end

      S_FWR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & ~(WORD_WIDTH'(1) << rem_q[BIT_W-1:0]);
        pend_st_d = bsa_pkg::ST_FREED;
        state_d   = S_EMIT;
      end

      S_CRD: begin
        state_d = S_CACC;
      end

      S_CACC: begin
        cnt_d = cnt_q + BASE_W'(free_cnt);
        if (last_word) begin
          state_d = S_CDEC;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          base_d  = base_q + BASE_W'(WORD_WIDTH);
          state_d = S_CRD;
        end
      end

      S_CDEC: begin
        ptr_d  = '0;
        base_d = '0;
        if (cnt_q < BASE_W'(req_q)) begin
          pend_st_d = bsa_pkg::ST_NO_FREE;
          state_d   = S_EMIT;
        end else begin
          state_d = S_PRD;
        end
      end

      S_PRD: begin
        state_d = S_PLOAD;
      end

      S_PLOAD: begin
        cur_d   = mem_rdata;
        avail_d = ~mem_rdata & valid_mask;
        state_d = S_PICK;
      end

      S_PICK: begin
        if (avail_q == '0) begin
          state_d = S_PWB;
        end else if (out_free) begin
          out_valid_d       = 1'b1;
          status_d          = bsa_pkg::ST_ALLOCATED;
          slot_d            = IDX_W'(base_q + BASE_W'(pick_bit));
          last_d            = (n_q + 1'b1 == req_q);
          cur_d[pick_bit]   = 1'b1;
          avail_d[pick_bit] = 1'b0;
          n_d               = n_q + 1'b1;
          if (n_q + 1'b1 == req_q) begin
            state_d = S_PWB;
          end
        end
      end

      S_PWB: begin
        mem_we = 1'b1;
        if (n_q == req_q) begin
          state_d = S_IDLE;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          base_d  = base_q + BASE_W'(WORD_WIDTH);
          state_d = S_PRD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      num_bits_q  <= bsa_pkg::NUM_BITS_RESET;
      ptr_q       <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      pend_st_q   <= bsa_pkg::ST_NO_FREE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      pend_st_q   <= pend_st_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        num_bits_q <= cfg_num_bits_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    cur_q    <= cur_d;
    avail_q  <= avail_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    last_q   <= last_d;
    if (in_fire) begin
      func_q  <= func_i;
      req_q   <= request_count_i;
      idx_q   <= free_index_i;
      blast_q <= batch_last_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign last_o      = last_q;

endmodule
